@@ sv/smrd_pkg.sv @@
// ----------------------------------------------------------------------------
// smrd_pkg: shared types and constants
// control word format, microprogram and configuration register map for the
// sliding median rise detector
// ----------------------------------------------------------------------------
package smrd_pkg;

    // configuration register map
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 12;
    localparam int THR_W      = 12;
    localparam int TOL_W      = 8;

    localparam logic [CFG_ADDR_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TOLERANCE = 2'd1;

    localparam logic [THR_W-1:0] THR_RESET = 12'd16;
    localparam logic [TOL_W-1:0] TOL_RESET = 8'd1;

    // microprogram step address
    typedef logic [2:0] t_step;

    localparam t_step STEP_ACCEPT  = 3'd0;
    localparam t_step STEP_CLEAR   = 3'd1;
    localparam t_step STEP_COMPARE = 3'd2;
    localparam t_step STEP_TEST    = 3'd3;
    localparam t_step STEP_EMIT    = 3'd4;

    typedef enum logic [2:0] {
        OP_ACCEPT,   // wait for a sample, store it in the ring
        OP_CLEAR,    // clear rank counters for the current candidate
        OP_COMPARE,  // compare candidate against one window entry
        OP_TEST,     // check candidate rank, capture median
        OP_EMIT      // load the output register
    } t_op;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NO_INPUT,
        C_J_MORE,
        C_NOT_FOUND,
        C_OUT_BUSY
    } t_cond;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step jmp;   // taken when cond holds
        t_step nxt;   // taken otherwise
    } t_ctrl;

    // control store
    function automatic t_ctrl ucode(input t_step step);
        t_ctrl cw;
        unique case (step)
            STEP_ACCEPT:  cw = '{OP_ACCEPT,  C_NO_INPUT,  STEP_ACCEPT,  STEP_CLEAR};
            STEP_CLEAR:   cw = '{OP_CLEAR,   C_ALWAYS,    STEP_COMPARE, STEP_COMPARE};
            STEP_COMPARE: cw = '{OP_COMPARE, C_J_MORE,    STEP_COMPARE, STEP_TEST};
            STEP_TEST:    cw = '{OP_TEST,    C_NOT_FOUND, STEP_CLEAR,   STEP_EMIT};
            STEP_EMIT:    cw = '{OP_EMIT,    C_OUT_BUSY,  STEP_EMIT,    STEP_ACCEPT};
            default:      cw = '{OP_CLEAR,   C_ALWAYS,    STEP_ACCEPT,  STEP_ACCEPT};
        endcase
        return cw;
    endfunction

endpackage

@@ sv/smrd_window.sv @@
// ----------------------------------------------------------------------------
// smrd_window: sample window store
// ring of WINDOW samples, one write port and two registered read ports,
// entries read as zero until first written after reset
// ----------------------------------------------------------------------------
module smrd_window #(
    parameter int WINDOW      = 5,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_we,
    input  logic [$clog2(WINDOW)-1:0]     i_waddr,
    input  logic signed [SAMPLE_BITS-1:0] i_wdata,
    input  logic [$clog2(WINDOW)-1:0]     i_raddr_a,
    input  logic [$clog2(WINDOW)-1:0]     i_raddr_b,
    output logic signed [SAMPLE_BITS-1:0] o_rdata_a,
    output logic signed [SAMPLE_BITS-1:0] o_rdata_b
);

    logic signed [SAMPLE_BITS-1:0] r_mem [WINDOW];
    logic [WINDOW-1:0]             r_vld;
    logic signed [SAMPLE_BITS-1:0] r_rd_a;
    logic signed [SAMPLE_BITS-1:0] r_rd_b;

    // entry valid bits stand in for the reset-to-zero of the store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_vld[i_raddr_a] ? r_mem[i_raddr_a] : '0;
        r_rd_b <= r_vld[i_raddr_b] ? r_mem[i_raddr_b] : '0;
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

@@ sv/sliding_median_rise_detector_top.sv @@
// ----------------------------------------------------------------------------
// sliding_median_rise_detector_top: sliding window median with rise detect
// keeps the last WINDOW temperature samples, reports their median and flags
// a sudden rise of the median against the median saved before each write
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one signed sample per transfer; m_axis returns one result
//   per sample (median and newest in tdata, window-full and rise in tuser).
//   limits are written through i_cfg_we / i_cfg_addr / i_cfg_data while idle
// timing
//   a microcoded sequencer finds the median by rank counting: each candidate
//   entry is cleared, compared against every window entry in turn and tested;
//   the search stops at the first candidate of rank WINDOW/2 and uses the
//   single compare unit; the result shows on m_axis the cycle after the
//   emit step
// reset
//   synchronous, active low: the window reads as all zero, fill count, write
//   slot and saved median clear, threshold 16 and tolerance 1, nothing pending
// stall
//   a finished result waits in the output register; the sequencer takes the
//   next sample meanwhile and waits at its emit step only while that register
//   is still held by a stalled receiver
// ----------------------------------------------------------------------------
module sliding_median_rise_detector_top #(
    parameter int WINDOW      = 5,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write port
    input  logic                                   i_cfg_we,
    input  logic [smrd_pkg::CFG_ADDR_W-1:0]        i_cfg_addr,
    input  logic [smrd_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    // sample stream
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,  // sample
    // result stream
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [((2*SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,  // median, newest
    output logic [1:0]                             m_axis_tuser   // window_full, sudden_rise
);

    localparam int IDX_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int OUT_W  = ((2*SAMPLE_BITS+7)/8)*8;
    // room for median difference and threshold sum without wrap
    localparam int CMP_W  = (SAMPLE_BITS + 2 > smrd_pkg::THR_W + 2) ?
                            SAMPLE_BITS + 2 : smrd_pkg::THR_W + 2;
    localparam logic [CNT_W-1:0] RANK = CNT_W'(WINDOW / 2);

    // sequencer
    smrd_pkg::t_step r_step, n_step;
    smrd_pkg::t_ctrl cw;
    logic            cond;

    // search datapath
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_j, n_j;
    logic [CNT_W-1:0] r_less, n_less;
    logic [CNT_W-1:0] r_eq, n_eq;
    logic signed [SAMPLE_BITS-1:0] rd_a, rd_b;
    logic             found;
    logic             j_more;

    // ring state
    logic [IDX_W-1:0] r_slot, n_slot;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic             full;
    logic             wr_en;
    logic signed [SAMPLE_BITS-1:0] sample;

    // medians
    logic signed [SAMPLE_BITS-1:0] r_median, n_median;
    logic signed [SAMPLE_BITS-1:0] r_last_med, n_last_med;
    logic signed [SAMPLE_BITS-1:0] r_saved, n_saved;
    logic                          r_saved_vld, n_saved_vld;
    logic signed [SAMPLE_BITS-1:0] r_newest, n_newest;

    // configuration
    logic [smrd_pkg::THR_W-1:0] r_thr;
    logic [smrd_pkg::TOL_W-1:0] r_tol;

    // rise compare
    logic signed [CMP_W-1:0] diff;
    logic signed [CMP_W-1:0] limit;
    logic                    rise;

    // output register
    logic                          r_out_vld;
    logic signed [SAMPLE_BITS-1:0] r_out_med;
    logic signed [SAMPLE_BITS-1:0] r_out_new;
    logic                          r_out_full;
    logic                          r_out_rise;
    logic                          out_busy;
    logic                          out_load;

    assign cw     = smrd_pkg::ucode(r_step);
    assign sample = $signed(s_axis_tdata[SAMPLE_BITS-1:0]);
    assign full   = (r_fill == CNT_W'(WINDOW));
    assign j_more = (r_j != IDX_W'(WINDOW - 1));
    // candidate holds rank WINDOW/2 when less <= RANK < less + equal
    assign found  = (r_less <= RANK) &&
                    ({1'b0, RANK} < ({1'b0, r_less} + {1'b0, r_eq}));
    assign out_busy = r_out_vld && !m_axis_tready;

    always_comb begin
        unique case (cw.cond)
            smrd_pkg::C_ALWAYS:    cond = 1'b1;
            smrd_pkg::C_NO_INPUT:  cond = !s_axis_tvalid;
            smrd_pkg::C_J_MORE:    cond = j_more;
            smrd_pkg::C_NOT_FOUND: cond = !found;
            smrd_pkg::C_OUT_BUSY:  cond = out_busy;
            default:               cond = 1'b1;
        endcase
    end

    assign s_axis_tready = (cw.op == smrd_pkg::OP_ACCEPT);
    assign wr_en         = s_axis_tready && s_axis_tvalid;
    assign out_load      = (cw.op == smrd_pkg::OP_EMIT) && !out_busy;

    // median rise against the saved median, both sides at full precision
    assign diff  = CMP_W'(r_median) - CMP_W'(r_saved);
    assign limit = CMP_W'(r_thr) + CMP_W'(r_tol);
    assign rise  = r_saved_vld && (diff > limit);

    always_comb begin
        n_step      = cond ? cw.jmp : cw.nxt;
        n_i         = r_i;
        n_j         = r_j;
        n_less      = r_less;
        n_eq        = r_eq;
        n_slot      = r_slot;
        n_fill      = r_fill;
        n_median    = r_median;
        n_last_med  = r_last_med;
        n_saved     = r_saved;
        n_saved_vld = r_saved_vld;
        n_newest    = r_newest;
        unique case (cw.op)
            smrd_pkg::OP_ACCEPT: begin
                n_i = '0;
                n_j = '0;
                if (s_axis_tvalid) begin
                    // window before this write equals the previous result's window
                    if (full) begin
                        n_saved     = r_last_med;
                        n_saved_vld = 1'b1;
                    end
                    n_slot   = (r_slot == IDX_W'(WINDOW - 1)) ? '0 :
                               IDX_W'(r_slot + 1'b1);
                    n_fill   = full ? r_fill : CNT_W'(r_fill + 1'b1);
                    n_newest = sample;
                end
            end
            smrd_pkg::OP_CLEAR: begin
                n_less = '0;
                n_eq   = '0;
                n_j    = '0;
            end
            smrd_pkg::OP_COMPARE: begin
                if (rd_b < rd_a) begin
                    n_less = CNT_W'(r_less + 1'b1);
                end
                if (rd_b == rd_a) begin
                    n_eq = CNT_W'(r_eq + 1'b1);
                end
                n_j = j_more ? IDX_W'(r_j + 1'b1) : '0;
            end
            smrd_pkg::OP_TEST: begin
                n_j = '0;
                if (found) begin
                    n_median = rd_a;
                    n_i      = '0;
                end else begin
                    n_i = IDX_W'(r_i + 1'b1);
                end
            end
            smrd_pkg::OP_EMIT: begin
                if (!out_busy) begin
                    n_last_med = r_median;
                end
            end
            default: begin
                n_step = smrd_pkg::STEP_ACCEPT;
            end
        endcase
    end

    // read ports follow the next indices so data lines up with r_i / r_j
    smrd_window #(
        .WINDOW      (WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (wr_en),
        .i_waddr   (r_slot),
        .i_wdata   (sample),
        .i_raddr_a (n_i),
        .i_raddr_b (n_j),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= smrd_pkg::STEP_ACCEPT;
            r_i         <= '0;
            r_j         <= '0;
            r_slot      <= '0;
            r_fill      <= '0;
            r_saved     <= '0;
            r_saved_vld <= 1'b0;
            r_last_med  <= '0;
            r_out_vld   <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_i         <= n_i;
            r_j         <= n_j;
            r_slot      <= n_slot;
            r_fill      <= n_fill;
            r_saved     <= n_saved;
            r_saved_vld <= n_saved_vld;
            r_last_med  <= n_last_med;
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_less   <= n_less;
        r_eq     <= n_eq;
        r_median <= n_median;
        r_newest <= n_newest;
        if (out_load) begin
            r_out_med  <= r_median;
            r_out_new  <= r_newest;
            r_out_full <= full;
            r_out_rise <= rise;
        end
    end

    // register writes, indexes beyond the map are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= smrd_pkg::THR_RESET;
            r_tol <= smrd_pkg::TOL_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                smrd_pkg::REG_THRESHOLD: r_thr <= i_cfg_data[smrd_pkg::THR_W-1:0];
                smrd_pkg::REG_TOLERANCE: r_tol <= i_cfg_data[smrd_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = OUT_W'({r_out_new, r_out_med});
    assign m_axis_tuser  = {r_out_rise, r_out_full};

endmodule

@@ sv/smrd_checker.sv @@
// ----------------------------------------------------------------------------
// smrd_checker: port-level checks
// watches the stream ports of the top level over time
// ----------------------------------------------------------------------------
module smrd_checker #(
    parameter int SAMPLE_BITS = 12
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_axis_tdata,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [((2*SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
    input logic [1:0]                         m_axis_tuser
);

    logic [SAMPLE_BITS-1:0] r_last_sample;

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_last_sample <= s_axis_tdata[SAMPLE_BITS-1:0];
        end
    end

    // held result stays put while the receiver stalls
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed under stall");

    // a fresh result carries the sample accepted just before
    a_newest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |->
            m_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS] == r_last_sample)
        else $error("newest field does not match last sample");

    // a rise needs a saved median, which needs a full window
    a_rise_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("rise flagged before window full");

    // reset drops any pending result
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result pending after reset");

endmodule

bind sliding_median_rise_detector_top smrd_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_smrd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
